FILE: hw/rtl/qsr_pkg.sv
// shared widths and types for the quaternion sandwich rotation pipeline
package qsr_pkg;

   localparam int COMPONENT_WIDTH = 16;
   localparam int FRAC_BITS       = COMPONENT_WIDTH - 1;
   // q * r component products and their four-term sums
   localparam int PROD_WIDTH      = 2 * COMPONENT_WIDTH;
   localparam int T_WIDTH         = PROD_WIDTH + 2;
   // r * t component products and their four-term sums
   localparam int PROD2_WIDTH     = COMPONENT_WIDTH + T_WIDTH;
   localparam int O_WIDTH         = PROD2_WIDTH + 2;

   // component order within a quaternion
   localparam int IDX_W = 0;
   localparam int IDX_X = 1;
   localparam int IDX_Y = 2;
   localparam int IDX_Z = 3;

   typedef logic signed [COMPONENT_WIDTH-1:0] comp_type;
   typedef logic signed [PROD_WIDTH-1:0]      prod_type;
   typedef logic signed [T_WIDTH-1:0]         tcomp_type;
   typedef logic signed [PROD2_WIDTH-1:0]     prod2_type;
   typedef logic signed [O_WIDTH-1:0]         ocomp_type;

endpackage

FILE: hw/rtl/qsr_conj_mul.sv
// two-stage pipeline forming t = q * conj(r) at full precision
module qsr_conj_mul import qsr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  comp_type  q [4],
   input  comp_type  r [4],
   output logic      out_valid,
   input  logic      out_ready,
   output tcomp_type t_out [4],
   output comp_type  r_out [4]
);

   logic      va_ff, vb_ff;
   logic      en_a, en_b;
   prod_type  prod_in [4][4];
   prod_type  prod_ff [4][4];
   comp_type  ra_ff [4];
   tcomp_type t_in [4];
   tcomp_type t_ff [4];
   comp_type  rb_ff [4];

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = prod_type'(q[i]) * prod_type'(r[j]);
         end
      end
   end

   // conjugate folded into the signs: p[i][j] = q_i * r_j
   always_comb begin
      t_in[IDX_W] = tcomp_type'(prod_ff[IDX_W][IDX_W]) + tcomp_type'(prod_ff[IDX_X][IDX_X])
                  + tcomp_type'(prod_ff[IDX_Y][IDX_Y]) + tcomp_type'(prod_ff[IDX_Z][IDX_Z]);
      t_in[IDX_X] = tcomp_type'(prod_ff[IDX_X][IDX_W]) - tcomp_type'(prod_ff[IDX_W][IDX_X])
                  - tcomp_type'(prod_ff[IDX_Y][IDX_Z]) + tcomp_type'(prod_ff[IDX_Z][IDX_Y]);
      t_in[IDX_Y] = tcomp_type'(prod_ff[IDX_Y][IDX_W]) - tcomp_type'(prod_ff[IDX_W][IDX_Y])
                  + tcomp_type'(prod_ff[IDX_X][IDX_Z]) - tcomp_type'(prod_ff[IDX_Z][IDX_X]);
      t_in[IDX_Z] = tcomp_type'(prod_ff[IDX_Z][IDX_W]) - tcomp_type'(prod_ff[IDX_W][IDX_Z])
                  - tcomp_type'(prod_ff[IDX_X][IDX_Y]) + tcomp_type'(prod_ff[IDX_Y][IDX_X]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         prod_ff <= prod_in;
         ra_ff   <= r;
      end
      if (en_b) begin
         t_ff  <= t_in;
         rb_ff <= ra_ff;
      end
   end

   assign out_valid = vb_ff;
   assign t_out     = t_ff;
   assign r_out     = rb_ff;

endmodule

FILE: hw/rtl/qsr_rot_mul.sv
// two-stage pipeline forming the exact product r * t
module qsr_rot_mul import qsr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  tcomp_type t [4],
   input  comp_type  r [4],
   output logic      out_valid,
   input  logic      out_ready,
   output ocomp_type o_out [4]
);

   logic      va_ff, vb_ff;
   logic      en_a, en_b;
   prod2_type prod_in [4][4];
   prod2_type prod_ff [4][4];
   ocomp_type o_in [4];
   ocomp_type o_ff [4];

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   // p[i][j] = r_i * t_j
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i][j] = prod2_type'(r[i]) * prod2_type'(t[j]);
         end
      end
   end

   always_comb begin
      o_in[IDX_W] = ocomp_type'(prod_ff[IDX_W][IDX_W]) - ocomp_type'(prod_ff[IDX_X][IDX_X])
                  - ocomp_type'(prod_ff[IDX_Y][IDX_Y]) - ocomp_type'(prod_ff[IDX_Z][IDX_Z]);
      o_in[IDX_X] = ocomp_type'(prod_ff[IDX_W][IDX_X]) + ocomp_type'(prod_ff[IDX_X][IDX_W])
                  + ocomp_type'(prod_ff[IDX_Y][IDX_Z]) - ocomp_type'(prod_ff[IDX_Z][IDX_Y]);
      o_in[IDX_Y] = ocomp_type'(prod_ff[IDX_W][IDX_Y]) - ocomp_type'(prod_ff[IDX_X][IDX_Z])
                  + ocomp_type'(prod_ff[IDX_Y][IDX_W]) + ocomp_type'(prod_ff[IDX_Z][IDX_X]);
      o_in[IDX_Z] = ocomp_type'(prod_ff[IDX_W][IDX_Z]) + ocomp_type'(prod_ff[IDX_X][IDX_Y])
                  - ocomp_type'(prod_ff[IDX_Y][IDX_X]) + ocomp_type'(prod_ff[IDX_Z][IDX_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= in_valid;
         end
         if (en_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         prod_ff <= prod_in;
      end
      if (en_b) begin
         o_ff <= o_in;
      end
   end

   assign out_valid = vb_ff;
   assign o_out     = o_ff;

endmodule

FILE: hw/rtl/qsr_round.sv
// output stage: round to nearest, saturate, and flag clipping
module qsr_round import qsr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  ocomp_type o [4],
   output logic      out_valid,
   input  logic      out_ready,
   output comp_type  res [4],
   output logic      res_sat
);

   localparam int EXT_WIDTH = O_WIDTH + 1;
   localparam int SHIFT     = 2 * FRAC_BITS;
   localparam int TOP_BIT   = SHIFT + COMPONENT_WIDTH - 1;
   localparam logic [EXT_WIDTH-1:0] HALF = EXT_WIDTH'(1) << (SHIFT - 1);
   localparam comp_type COMP_MAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
   localparam comp_type COMP_MIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

   logic                          v_ff;
   logic                          en;
   logic [EXT_WIDTH-1:0]          biased [4];
   logic [EXT_WIDTH-1-TOP_BIT:0]  hi_bits [4];
   logic [3:0]                    clip;
   comp_type                      res_in [4];
   comp_type                      res_ff [4];
   logic                          sat_in, sat_ff;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   // add half a step, keep the bits above the dropped fraction
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         biased[i]  = {o[i][O_WIDTH-1], o[i]} + HALF;
         hi_bits[i] = biased[i][EXT_WIDTH-1:TOP_BIT];
         clip[i]    = !((&hi_bits[i]) || !(|hi_bits[i]));
         if (!clip[i]) begin
            res_in[i] = biased[i][TOP_BIT:SHIFT];
         end else if (biased[i][EXT_WIDTH-1]) begin
            res_in[i] = COMP_MIN;
         end else begin
            res_in[i] = COMP_MAX;
         end
      end
      sat_in = |clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = v_ff;
   assign res       = res_ff;
   assign res_sat   = sat_ff;

endmodule

FILE: hw/rtl/quaternion_sandwich_rotate_top.sv
// top level of the quaternion sandwich rotation pipeline, r * q * conj(r)
//
// usage
// - request channel: req_valid / req_ready carry q (req_q_*) and the rotation
//   quaternion r (req_r_*), all signed q1.15
// - response channel: rsp_valid / rsp_ready carry the rotated components
//   (rsp_out_*), rounded to nearest and saturated, plus rsp_saturated when any
//   component was clipped
// - five register stages: the q * conj(r) products, their sums, the r * t
//   products, their sums, then rounding into the output register
// - the accepting edge loads the first stage, and the request then moves on through the
//   remaining stages in the order above before rsp_valid rises; one request is taken
//   every cycle while the response side keeps up
// - throughput is set by the sixteen multipliers of each product stage, one
//   set working per cycle while the response side keeps up
// - a stalled response holds the output register; each stage advances when it
//   is empty or the stage after it moves, so bubbles are filled and nothing is
//   dropped or repeated
// - reset clears only the stage valid bits; no state is carried between requests
module quaternion_sandwich_rotate_top import qsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  comp_type req_q_w,
   input  comp_type req_q_x,
   input  comp_type req_q_y,
   input  comp_type req_q_z,
   input  comp_type req_r_w,
   input  comp_type req_r_x,
   input  comp_type req_r_y,
   input  comp_type req_r_z,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output comp_type rsp_out_w,
   output comp_type rsp_out_x,
   output comp_type rsp_out_y,
   output comp_type rsp_out_z,
   output logic     rsp_saturated
);

   comp_type  q_vec [4];
   comp_type  r_vec [4];
   tcomp_type t_vec [4];
   comp_type  r_dly [4];
   ocomp_type o_vec [4];
   comp_type  res_vec [4];
   logic      t_valid, t_ready;
   logic      o_valid, o_ready;

   // gather the request components into quaternion vectors
   assign q_vec[IDX_W] = req_q_w;
   assign q_vec[IDX_X] = req_q_x;
   assign q_vec[IDX_Y] = req_q_y;
   assign q_vec[IDX_Z] = req_q_z;
   assign r_vec[IDX_W] = req_r_w;
   assign r_vec[IDX_X] = req_r_x;
   assign r_vec[IDX_Y] = req_r_y;
   assign r_vec[IDX_Z] = req_r_z;

   // t = q * conj(r), exact
   qsr_conj_mul u_conj_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .q         (q_vec),
      .r         (r_vec),
      .out_valid (t_valid),
      .out_ready (t_ready),
      .t_out     (t_vec),
      .r_out     (r_dly)
   );

   // r * t, exact, with r delayed alongside t
   qsr_rot_mul u_rot_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t_valid),
      .in_ready  (t_ready),
      .t         (t_vec),
      .r         (r_dly),
      .out_valid (o_valid),
      .out_ready (o_ready),
      .o_out     (o_vec)
   );

   // back to q1.15 with rounding and clipping
   qsr_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (o_valid),
      .in_ready  (o_ready),
      .o         (o_vec),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .res       (res_vec),
      .res_sat   (rsp_saturated)
   );

   assign rsp_out_w = res_vec[IDX_W];
   assign rsp_out_x = res_vec[IDX_X];
   assign rsp_out_y = res_vec[IDX_Y];
   assign rsp_out_z = res_vec[IDX_Z];

endmodule

FILE: bench/qsr_rotate_checker.sv
// response checker for the quaternion sandwich rotation pipeline
module qsr_rotate_checker import qsr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  comp_type req_q_w,
   input  comp_type req_q_x,
   input  comp_type req_q_y,
   input  comp_type req_q_z,
   input  comp_type req_r_w,
   input  comp_type req_r_x,
   input  comp_type req_r_y,
   input  comp_type req_r_z,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  comp_type rsp_out_w,
   input  comp_type rsp_out_x,
   input  comp_type rsp_out_y,
   input  comp_type rsp_out_z,
   input  logic     rsp_saturated,
   output int       fail_count,
   output int       pending_count,
   output int       request_count,
   output int       clipped_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef longint wide_quat_type [4];

   typedef struct {
      comp_type w;
      comp_type x;
      comp_type y;
      comp_type z;
      logic     clipped;
   } rotated_type;

   rotated_type rotated_q[$];
   rotated_type oldest;
   int          mismatches = 0;
   int          requests   = 0;
   int          clipped    = 0;

   // hamilton convention, i*j = k
   function automatic void hamilton_product(input wide_quat_type a, input wide_quat_type b,
                                            output wide_quat_type o);
      o[IDX_W] = a[IDX_W] * b[IDX_W] - a[IDX_X] * b[IDX_X]
               - a[IDX_Y] * b[IDX_Y] - a[IDX_Z] * b[IDX_Z];
      o[IDX_X] = a[IDX_W] * b[IDX_X] + a[IDX_X] * b[IDX_W]
               + a[IDX_Y] * b[IDX_Z] - a[IDX_Z] * b[IDX_Y];
      o[IDX_Y] = a[IDX_W] * b[IDX_Y] - a[IDX_X] * b[IDX_Z]
               + a[IDX_Y] * b[IDX_W] + a[IDX_Z] * b[IDX_X];
      o[IDX_Z] = a[IDX_W] * b[IDX_Z] + a[IDX_X] * b[IDX_Y]
               - a[IDX_Y] * b[IDX_X] + a[IDX_Z] * b[IDX_W];
   endfunction

   // 3F fraction bits down to F, half rounds up, clip at the range limits
   function automatic comp_type round_clip(input longint v, inout logic hit);
      longint scaled;
      longint top;
      longint bottom;
      top    = (longint'(1) << FRAC_BITS) - 1;
      bottom = -(longint'(1) << FRAC_BITS);
      scaled = (v + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      if (scaled > top) begin
         hit = 1'b1;
         return comp_type'(top);
      end
      if (scaled < bottom) begin
         hit = 1'b1;
         return comp_type'(bottom);
      end
      return comp_type'(scaled);
   endfunction

   function automatic rotated_type rotate_sandwich(input comp_type qw, qx, qy, qz,
                                                   input comp_type rw, rx, ry, rz);
      wide_quat_type q, r, r_conj, t, o;
      rotated_type   res;
      logic          hit;
      q[IDX_W] = qw;
      q[IDX_X] = qx;
      q[IDX_Y] = qy;
      q[IDX_Z] = qz;
      r[IDX_W] = rw;
      r[IDX_X] = rx;
      r[IDX_Y] = ry;
      r[IDX_Z] = rz;
      r_conj[IDX_W] = r[IDX_W];
      r_conj[IDX_X] = -r[IDX_X];
      r_conj[IDX_Y] = -r[IDX_Y];
      r_conj[IDX_Z] = -r[IDX_Z];
      hamilton_product(q, r_conj, t);
      hamilton_product(r, t, o);
      hit   = 1'b0;
      res.w = round_clip(o[IDX_W], hit);
      res.x = round_clip(o[IDX_X], hit);
      res.y = round_clip(o[IDX_Y], hit);
      res.z = round_clip(o[IDX_Z], hit);
      res.clipped = hit;
      return res;
   endfunction

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            rotated_q.push_back(rotate_sandwich(req_q_w, req_q_x, req_q_y, req_q_z,
                                                req_r_w, req_r_x, req_r_y, req_r_z));
            requests++;
         end
         if (rsp_valid && rsp_ready) begin
            if (rotated_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               oldest = rotated_q.pop_front();
               compare_field("out_w", oldest.w, rsp_out_w);
               compare_field("out_x", oldest.x, rsp_out_x);
               compare_field("out_y", oldest.y, rsp_out_y);
               compare_field("out_z", oldest.z, rsp_out_z);
               compare_field("saturated", {31'd0, oldest.clipped}, {31'd0, rsp_saturated});
               if (oldest.clipped) begin
                  clipped++;
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= rotated_q.size();
      request_count <= requests;
      clipped_count <= clipped;
   end

endmodule

FILE: bench/quaternion_sandwich_rotate_top_tb.sv
// testbench top for the quaternion sandwich rotation pipeline
module quaternion_sandwich_rotate_top_tb import qsr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // run length and timing
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_REQUESTS = 1500;
   localparam int PHASE_COUNT     = 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 20;

   // full-scale operands, +1.0 less one step and -1.0
   localparam comp_type COMP_MAX = comp_type'((1 << FRAC_BITS) - 1);
   localparam comp_type COMP_MIN = comp_type'(-(1 << FRAC_BITS));
   // roughly sqrt(0.5), for quarter-turn rotations
   localparam comp_type COMP_HALF_ROOT = comp_type'(23170);
   // 0.5, and one step either side of zero
   localparam comp_type COMP_HALF     = comp_type'(16384);
   localparam comp_type COMP_STEP     = comp_type'(1);
   localparam comp_type COMP_NEG_STEP = comp_type'(-1);

   // idling per phase: none, sender idle, receiver stalling, both
   localparam int PHASE_SEND_IDLE [PHASE_COUNT] = '{0, 64, 0, 23};
   localparam int PHASE_RSP_STALL [PHASE_COUNT] = '{0, 0, 64, 23};

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_ready;
   comp_type req_q_w, req_q_x, req_q_y, req_q_z;
   comp_type req_r_w, req_r_x, req_r_y, req_r_z;
   logic     rsp_valid;
   logic     rsp_ready;
   comp_type rsp_out_w, rsp_out_x, rsp_out_y, rsp_out_z;
   logic     rsp_saturated;

   int fail_count;
   int pending_count;
   int request_count;
   int clipped_count;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycle_count   = 0;
   bit long_hold     = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   quaternion_sandwich_rotate_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_q_w       (req_q_w),
      .req_q_x       (req_q_x),
      .req_q_y       (req_q_y),
      .req_q_z       (req_q_z),
      .req_r_w       (req_r_w),
      .req_r_x       (req_r_x),
      .req_r_y       (req_r_y),
      .req_r_z       (req_r_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_w     (rsp_out_w),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated)
   );

   // the checker watches both channels, predicts each response and compares
   qsr_rotate_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_q_w       (req_q_w),
      .req_q_x       (req_q_x),
      .req_q_y       (req_q_y),
      .req_q_z       (req_q_z),
      .req_r_w       (req_r_w),
      .req_r_x       (req_r_x),
      .req_r_y       (req_r_y),
      .req_r_z       (req_r_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_w     (rsp_out_w),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .request_count (request_count),
      .clipped_count (clipped_count)
   );

   // one request: random idle cycles first, then hold it until it is taken
   // entered and left on a falling edge, so each edge sees one assignment at most
   task automatic offer_request(input comp_type qw, qx, qy, qz,
                                input comp_type rw, rx, ry, rz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_q_w   <= qw;
      req_q_x   <= qx;
      req_q_y   <= qy;
      req_q_z   <= qz;
      req_r_w   <= rw;
      req_r_x   <= rx;
      req_r_y   <= ry;
      req_r_z   <= rz;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   // full range, half scale (|r| no more than one) or one of the extremes
   function automatic comp_type draw_component(input int style);
      case (style)
         0: begin
            return comp_type'($urandom);
         end
         1: begin
            return comp_type'(int'($urandom_range(32767)) - 16384);
         end
         default: begin
            case ($urandom_range(4))
               0: return COMP_MIN;
               1: return comp_type'(-1);
               2: return comp_type'(0);
               3: return comp_type'(1);
               default: return COMP_MAX;
            endcase
         end
      endcase
   endfunction

   // receiver: random stalls, or one long hold-off counted here so the pipe backs up
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus and verdict
   initial begin
      int       q_style;
      int       r_style;
      comp_type qa [4];
      comp_type ra [4];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_q_w   = '0;
      req_q_x   = '0;
      req_q_y   = '0;
      req_q_z   = '0;
      req_r_w   = '0;
      req_r_x   = '0;
      req_r_y   = '0;
      req_r_z   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed requests, back to back
      // all zero
      offer_request('0, '0, '0, '0, '0, '0, '0, '0);
      // near-identity rotation on full-scale q
      offer_request(COMP_MAX, COMP_MIN, COMP_STEP, COMP_NEG_STEP, COMP_MAX, '0, '0, '0);
      // r = -1.0 exactly, so q passes through unchanged, -1.0 included
      offer_request(COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, '0, '0, '0);
      // every component at -1.0, and every one at full positive scale
      offer_request(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                    COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
      offer_request(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                    COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
      // r = 0.5 quarters q: exact halfway values, both signs, to check round-up, then quarter steps
      offer_request(comp_type'(2), comp_type'(-2), comp_type'(6), comp_type'(-6),
                    COMP_HALF, '0, '0, '0);
      offer_request(comp_type'(-3), comp_type'(3), COMP_NEG_STEP, COMP_STEP,
                    COMP_HALF, '0, '0, '0);
      // quarter turns about each axis
      offer_request('0, '0, COMP_HALF, '0, COMP_HALF_ROOT, COMP_HALF_ROOT, '0, '0);
      offer_request('0, '0, '0, COMP_HALF, COMP_HALF_ROOT, '0, COMP_HALF_ROOT, '0);
      offer_request('0, COMP_HALF, '0, '0, COMP_HALF_ROOT, '0, '0, COMP_HALF_ROOT);
      // half turn about x negates y and z, -1.0 operands included
      offer_request(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, '0, COMP_MAX, '0, '0);
      // non-unit r, saturation both ways
      offer_request(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MIN, COMP_MIN, '0, '0);
      offer_request(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN,
                    COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
      // tiny r, everything rounds to zero
      offer_request(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                    COMP_STEP, COMP_STEP, COMP_STEP, COMP_STEP);
      offer_request(COMP_NEG_STEP, COMP_NEG_STEP, COMP_NEG_STEP, COMP_NEG_STEP,
                    COMP_NEG_STEP, COMP_NEG_STEP, COMP_NEG_STEP, COMP_NEG_STEP);

      // random requests across the idling phases
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct = PHASE_SEND_IDLE[phase];
         rsp_stall_pct = PHASE_RSP_STALL[phase];
         // the sender keeps offering while the receiver holds off
         if (phase == 0) begin
            long_hold = 1'b1;
         end
         for (int n = 0; n < RANDOM_REQUESTS / PHASE_COUNT; n++) begin
            q_style = ($urandom_range(9) < 8) ? 0 : 2;
            r_style = $urandom_range(9);
            r_style = (r_style < 4) ? 0 : (r_style < 8) ? 1 : 2;
            for (int c = 0; c < 4; c++) begin
               qa[c] = draw_component(q_style);
               ra[c] = draw_component(r_style);
            end
            offer_request(qa[IDX_W], qa[IDX_X], qa[IDX_Y], qa[IDX_Z],
                          ra[IDX_W], ra[IDX_X], ra[IDX_Y], ra[IDX_Z]);
         end
      end
      req_valid <= 1'b0;

      // drain every outstanding response, then let the pipe settle
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("rotated %0d requests over four idling phases and a long receiver hold-off",
               request_count);
      $display("%0d responses came back clipped, %0d failures seen",
               clipped_count, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: quaternion_sandwich_rotate_top.f
hw/rtl/qsr_pkg.sv
hw/rtl/qsr_conj_mul.sv
hw/rtl/qsr_rot_mul.sv
hw/rtl/qsr_round.sv
hw/rtl/quaternion_sandwich_rotate_top.sv
bench/qsr_rotate_checker.sv
bench/quaternion_sandwich_rotate_top_tb.sv
